>>> rtl/aes_ke_pkg.sv
package aes_ke_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned KEY_WORDS = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(43);
    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1B;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,
        8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,
        8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,
        8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,
        8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,
        8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,
        8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,
        8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,
        8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,
        8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,
        8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,
        8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,
        8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,
        8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,
        8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,
        8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,
        8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [WORD_W-1:0] rot_word(input logic [WORD_W-1:0] v);
        return {v[23:0], v[31:24]};
    endfunction

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

>>> rtl/aes_ke_step.sv
module aes_ke_step (
    input  logic [aes_ke_pkg::WORD_W-1:0] i_w_back4,
    input  logic [aes_ke_pkg::WORD_W-1:0] i_w_back1,
    input  logic [7:0]                    i_rcon,
    input  logic                          i_round_start,
    output logic [aes_ke_pkg::WORD_W-1:0] o_w_next
);

    logic [aes_ke_pkg::WORD_W-1:0] w_mixed;

    always_comb begin
        if (i_round_start) begin
            w_mixed = aes_ke_pkg::sub_word(aes_ke_pkg::rot_word(i_w_back1))
                      ^ {i_rcon, 24'h000000};
        end else begin
            w_mixed = i_w_back1;
        end
    end

    assign o_w_next = i_w_back4 ^ w_mixed;

endmodule

>>> rtl/aes128_key_expansion_top.sv
// AES-128 key schedule generator. The cipher key enters as four 32-bit beats, first key
// byte in bits 31:24. Each of the first three beats is echoed at once as expanded word 0,
// 1 or 2 with last set. The fourth beat is echoed as word 3 and is followed by words 4 to
// 43, one per cycle while the output is not stalled, with last set on word 43; the input
// is held off during that run, so no new key beat is taken until word 43 has been issued.
// A single next-word unit (RotWord, SubWord through four S-box lookups and the round
// constant) works on a four-word sliding window.
module aes128_key_expansion_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_key_valid,
    output logic                          o_key_ready,
    input  logic [aes_ke_pkg::WORD_W-1:0] i_key_word,
    output logic                          o_word_valid,
    input  logic                          i_word_ready,
    output logic [aes_ke_pkg::IDX_W-1:0]  o_word_index,
    output logic [aes_ke_pkg::WORD_W-1:0] o_round_word,
    output logic                          o_last
);

    aes_ke_pkg::t_state r_state, n_state;
    logic [1:0]                    r_rcvd, n_rcvd;
    logic [aes_ke_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [7:0]                    r_rcon, n_rcon;
    logic [aes_ke_pkg::WORD_W-1:0] r_win [0:3];
    logic [aes_ke_pkg::WORD_W-1:0] n_win [0:3];
    logic                          r_out_valid, n_out_valid;
    logic [aes_ke_pkg::IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [aes_ke_pkg::WORD_W-1:0] r_out_word, n_out_word;
    logic                          r_out_last, n_out_last;

    logic                          w_slot_free;
    logic                          w_key_acc;
    logic                          w_round_start;
    logic [aes_ke_pkg::WORD_W-1:0] w_next;

    assign w_slot_free   = !r_out_valid || i_word_ready;
    assign o_key_ready   = (r_state == aes_ke_pkg::S_IDLE) && w_slot_free;
    assign w_key_acc     = i_key_valid && o_key_ready;
    assign w_round_start = (r_idx[1:0] == 2'b00);

    aes_ke_step u_step (
        .i_w_back4     (r_win[0]),
        .i_w_back1     (r_win[3]),
        .i_rcon        (r_rcon),
        .i_round_start (w_round_start),
        .o_w_next      (w_next)
    );

    always_comb begin
        n_state     = r_state;
        n_rcvd      = r_rcvd;
        n_idx       = r_idx;
        n_rcon      = r_rcon;
        n_win       = r_win;
        n_out_valid = r_out_valid && !i_word_ready;
        n_out_idx   = r_out_idx;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;
        case (r_state)
            aes_ke_pkg::S_IDLE: begin
                if (w_key_acc) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = aes_ke_pkg::IDX_W'(r_rcvd);
                    n_out_word  = i_key_word;
                    n_rcvd      = r_rcvd + 2'd1;
                    n_win[r_rcvd] = i_key_word;
                    if (r_rcvd == 2'(aes_ke_pkg::KEY_WORDS - 1)) begin
                        n_out_last = 1'b0;
                        n_idx      = aes_ke_pkg::IDX_W'(aes_ke_pkg::KEY_WORDS);
                        n_rcon     = aes_ke_pkg::RCON_FIRST;
                        n_state    = aes_ke_pkg::S_RUN;
                    end else begin
                        n_out_last = 1'b1;
                    end
                end
            end
            aes_ke_pkg::S_RUN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_idx;
                    n_out_word  = w_next;
                    n_out_last  = (r_idx == aes_ke_pkg::LAST_IDX);
                    n_win[0]    = r_win[1];
                    n_win[1]    = r_win[2];
                    n_win[2]    = r_win[3];
                    n_win[3]    = w_next;
                    n_idx       = r_idx + aes_ke_pkg::IDX_W'(1);
                    if (w_round_start) begin
                        n_rcon = aes_ke_pkg::xtime(r_rcon);
                    end
                    if (r_idx == aes_ke_pkg::LAST_IDX) begin
                        n_state = aes_ke_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = aes_ke_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aes_ke_pkg::S_IDLE;
            r_rcvd      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rcvd      <= n_rcvd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rcon     <= n_rcon;
        r_win      <= n_win;
        r_out_idx  <= n_out_idx;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    assign o_word_valid = r_out_valid;
    assign o_word_index = r_out_idx;
    assign o_round_word = r_out_word;
    assign o_last       = r_out_last;

    a_no_key_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_ke_pkg::S_RUN) |-> !o_key_ready)
        else $error("key beat taken while the schedule is running");

    a_fourth_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_key_acc && r_rcvd == 2'd3) |=> (r_state == aes_ke_pkg::S_RUN && r_rcvd == 2'd0))
        else $error("fourth key beat did not start the schedule run");

    a_run_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_ke_pkg::S_RUN && o_word_valid && i_word_ready) |=> o_word_valid)
        else $error("schedule run left a gap in the output");

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word_valid && o_last) |->
            (o_word_index == aes_ke_pkg::LAST_IDX || o_word_index < 6'd3))
        else $error("last flag on an unexpected word");

endmodule
